// File: rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared codes, widths and reset values for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned TIME_W      = 16;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef logic [TIME_W-1:0]      time_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // status codes
  localparam status_t ST_OFF      = 3'd0;
  localparam status_t ST_PRESSED  = 3'd1;
  localparam status_t ST_SHORT    = 3'd2;
  localparam status_t ST_LONG     = 3'd3;
  localparam status_t ST_HOLD     = 3'd4;
  localparam status_t ST_SUPER    = 3'd5;
  localparam status_t ST_RELEASED = 3'd6;

  // configuration register indexes
  localparam cfg_index_t REG_ACTIVE_LEVEL     = 3'd0;
  localparam cfg_index_t REG_SHORT_TIME       = 3'd1;
  localparam cfg_index_t REG_LONG_TIME        = 3'd2;
  localparam cfg_index_t REG_HOLD_TIME        = 3'd3;
  localparam cfg_index_t REG_FAST_REPEAT_TIME = 3'd4;
  localparam cfg_index_t REG_REPEATS_TO_FAST  = 3'd5;

  // reset values
  localparam logic   RST_ACTIVE_LEVEL     = 1'b1;
  localparam time_t  RST_SHORT_TIME       = 16'd50;
  localparam time_t  RST_LONG_TIME        = 16'd1000;
  localparam time_t  RST_HOLD_TIME        = 16'd200;
  localparam time_t  RST_FAST_REPEAT_TIME = 16'd50;
  localparam count_t RST_REPEATS_TO_FAST  = 8'd5;

  localparam time_t  TIME_MAX  = '1;
  localparam count_t COUNT_MAX = '1;

endpackage

// File: rtl/core/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// Long-press and auto-repeat classifier for one button, one tick per item.
// ----------------------------------------------------------------------------
// Each accepted item is one tick: the raw pin level and the milliseconds since
// the previous tick. The block takes one item every clock cycle while in_stall
// is low. All of the work for a tick is one saturating 16-bit add and a few
// compares feeding the state, timer and repeat count registers. The result
// side has a two-entry output buffer, so in_stall rises only after the
// downstream side has stalled with a result waiting and a second result has
// arrived. Configuration is written through cfg_write, cfg_index and
// cfg_data; the user must do so only while no tick is in flight, as the block
// does not enforce it. Indexes above five are ignored.
module button_press_classifier (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  bpc_pkg::cfg_index_t  cfg_index,
  input  bpc_pkg::cfg_data_t   cfg_data,
  // tick items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 pin_level,
  input  bpc_pkg::time_t       elapsed_ms,
  // status items
  output logic                 out_valid,
  input  logic                 out_stall,
  output bpc_pkg::status_t     button_status
);
  import bpc_pkg::*;

  // configuration registers
  logic   active_level;
  time_t  short_time;
  time_t  long_time;
  time_t  hold_time;
  time_t  fast_repeat_time;
  count_t repeats_to_fast;

  // classifier state
  status_t status_reg, status_reg_next;
  time_t   press_timer, press_timer_next;
  count_t  repeat_count, repeat_count_next;

  // output buffer
  logic    skid_valid;
  status_t skid_status;

  logic                in_acc;
  logic                pressed;
  logic [TIME_W:0]     timer_sum;
  time_t               timer_sat;
  logic [TIME_W:0]     long_hold;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign pressed  = (pin_level == active_level);

  assign timer_sum = {1'b0, press_timer} + {1'b0, elapsed_ms};
  assign timer_sat = timer_sum[TIME_W] ? TIME_MAX : timer_sum[TIME_W-1:0];
  // formed at 17 bits, a saturated timer never reaches a sum past the top
  assign long_hold = {1'b0, long_time} + {1'b0, hold_time};

  always_comb begin
    status_reg_next   = status_reg;
    press_timer_next  = press_timer;
    repeat_count_next = repeat_count;
    if (pressed) begin
      case (status_reg)
        ST_OFF: begin
          repeat_count_next = '0;
          press_timer_next  = '0;
          status_reg_next   = ST_PRESSED;
        end
        ST_PRESSED: begin
          press_timer_next = timer_sat;
          if (timer_sat >= long_time) status_reg_next = ST_LONG;
        end
        ST_LONG: begin
          press_timer_next = timer_sat;
          if ({1'b0, timer_sat} >= long_hold) begin
            press_timer_next = '0;
            status_reg_next  = ST_HOLD;
          end
        end
        ST_HOLD: begin
          press_timer_next = timer_sat;
          if (timer_sat >= hold_time) begin
            press_timer_next = '0;
            if (repeat_count != COUNT_MAX) repeat_count_next = repeat_count + 1'b1;
            status_reg_next = ST_SHORT;
          end
        end
        ST_SHORT: begin
          status_reg_next = (repeat_count >= repeats_to_fast) ? ST_SUPER : ST_HOLD;
        end
        ST_SUPER: begin
          press_timer_next = timer_sat;
          if (timer_sat >= fast_repeat_time) begin
            press_timer_next = '0;
            status_reg_next  = ST_SHORT;
          end
        end
        default: status_reg_next = ST_OFF;
      endcase
    end else begin
      case (status_reg)
        ST_PRESSED: begin
          if (press_timer >= long_time)       status_reg_next = ST_LONG;
          else if (press_timer >= short_time) status_reg_next = ST_SHORT;
          else                                status_reg_next = ST_OFF;
        end
        ST_HOLD, ST_SUPER, ST_LONG, ST_SHORT: status_reg_next = ST_RELEASED;
        default:                              status_reg_next = ST_OFF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level     <= RST_ACTIVE_LEVEL;
      short_time       <= RST_SHORT_TIME;
      long_time        <= RST_LONG_TIME;
      hold_time        <= RST_HOLD_TIME;
      fast_repeat_time <= RST_FAST_REPEAT_TIME;
      repeats_to_fast  <= RST_REPEATS_TO_FAST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_LEVEL:     active_level     <= cfg_data[0];
        REG_SHORT_TIME:       short_time       <= cfg_data[TIME_W-1:0];
        REG_LONG_TIME:        long_time        <= cfg_data[TIME_W-1:0];
        REG_HOLD_TIME:        hold_time        <= cfg_data[TIME_W-1:0];
        REG_FAST_REPEAT_TIME: fast_repeat_time <= cfg_data[TIME_W-1:0];
        REG_REPEATS_TO_FAST:  repeats_to_fast  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg   <= ST_OFF;
      press_timer  <= '0;
      repeat_count <= '0;
    end else if (in_acc) begin
      status_reg   <= status_reg_next;
      press_timer  <= press_timer_next;
      repeat_count <= repeat_count_next;
    end
  end

  // main output slot plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) button_status <= skid_status;
      else if (in_acc) button_status <= status_reg_next;
    end else if (in_acc) begin
      skid_status <= status_reg_next;
    end
  end

  // skid entry is only ever used behind a full output slot
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry holds an item while the output slot is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (in_acc && out_valid && out_stall) |=> in_stall)
    else $error("item accepted behind a stalled result was not buffered");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> ($stable(status_reg) && $stable(press_timer) && $stable(repeat_count)))
    else $error("classifier state moved without an accepted item");

  a_press_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && pressed && status_reg == ST_OFF) |=>
      (status_reg == ST_PRESSED && press_timer == '0 && repeat_count == '0))
    else $error("new press did not clear timer and repeat count");

endmodule
